FILE: sv/apba_pkg.sv
// Shared types and constants of the address pool bitmap allocator.
`default_nettype none
package apba_pkg;

  localparam int ADDR_W   = 32;
  localparam int PREFIX_W = 5;
  localparam int CMD_W    = 2;

  // Stream word widths: fields packed from bit 0 up, padded to whole bytes.
  localparam int IN_BITS  = 40;
  localparam int OUT_BITS = 72;

  localparam logic [PREFIX_W-1:0] MAX_PREFIX   = 5'd30;
  localparam logic [PREFIX_W-1:0] PREFIX_RESET = 5'd24;

  // Configuration register indexes.
  localparam logic REG_POOL_BASE  = 1'b0;
  localparam logic REG_PREFIX_LEN = 1'b1;

  typedef enum logic [CMD_W-1:0] {
    CMD_ALLOC   = 2'd0,
    CMD_RELEASE = 2'd1,
    CMD_RESERVE = 2'd2,
    CMD_INIT    = 2'd3
  } cmd_t;

  typedef enum logic [7:0] {
    ST_IDLE    = 8'b0000_0001,
    ST_DIV     = 8'b0000_0010,
    ST_FILL    = 8'b0000_0100,
    ST_SCAN_GO = 8'b0000_1000,
    ST_SCAN    = 8'b0001_0000,
    ST_MARK_RD = 8'b0010_0000,
    ST_MARK_WR = 8'b0100_0000,
    ST_DONE    = 8'b1000_0000
  } state_t;

endpackage
`default_nettype wire

FILE: sv/apba_div.sv
// Divider of a 32-bit value by a fixed power-of-two divisor: registered shift and mask.
`default_nettype none
module apba_div #(
  parameter int DIVISOR = 64
) (
  input  wire logic                              clk,
  input  wire logic                              rst,
  input  wire logic                              start,
  input  wire logic [apba_pkg::ADDR_W-1:0]       dividend,
  output logic                                   done,
  output logic [apba_pkg::ADDR_W-1:0]            quotient,
  output logic [$clog2(DIVISOR)-1:0]             remainder
);
  localparam int BW = $clog2(DIVISOR);

  always_ff @(posedge clk) begin
    if (rst) begin
      done <= 1'b0;
    end else begin
      done <= start;
    end
  end

  // Quotient is the dividend shifted down, remainder its low bits.
  always_ff @(posedge clk) begin
    if (start) begin
      quotient  <= dividend >> BW;
      remainder <= dividend[BW-1:0];
    end
  end

endmodule
`default_nettype wire

FILE: sv/apba_ffs.sv
// Lowest set bit finder of one bitmap word, with the word that bit cleared.
`default_nettype none
module apba_ffs #(
  parameter int WORD_BITS = 64
) (
  input  wire logic [WORD_BITS-1:0]          word,
  output logic                               found,
  output logic [$clog2(WORD_BITS)-1:0]       index,
  output logic [WORD_BITS-1:0]               cleared
);
  localparam int BW = $clog2(WORD_BITS);

  logic [WORD_BITS-1:0] iso;

  // Isolate the lowest one, then encode its position.
  assign iso     = word & (~word + WORD_BITS'(1));
  assign found   = word != '0;
  assign cleared = word & (word - WORD_BITS'(1));

  always_comb begin
    index = '0;
    for (int j = 0; j < WORD_BITS; j++) begin
      if (iso[j]) begin
        index = index | BW'(j);
      end
    end
  end

endmodule
`default_nettype wire

FILE: sv/address_pool_bitmap_allocator.sv
// Address pool allocator over a free bitmap held in one memory of POOL_WORDS words.
// Allocate: scan from the remembered word, one word per cycle, up to 2*POOL_WORDS words with wrap.
// Release/reserve: shift, read, write back, output; a dropped command goes on to the output.
// Init: shift, then one memory write per pool word, then output; a bad prefix goes straight to the output.
// One command at a time; ready is low until the result is in the output register.
// Reset (synchronous): empty pool, pool_base 0, prefix_len 24; the map is rewritten at init.
`default_nettype none
module address_pool_bitmap_allocator #(
  parameter int WORD_BITS  = 64,
  parameter int POOL_WORDS = 64
) (
  input  wire logic                              clk,
  input  wire logic                              rst,
  // configuration write port
  input  wire logic                              cfg_we,
  input  wire logic                              cfg_index,
  input  wire logic [apba_pkg::ADDR_W-1:0]       cfg_data,
  // command stream
  input  wire logic                              s_tvalid,
  output logic                                   s_tready,
  input  wire logic [apba_pkg::IN_BITS-1:0]      s_tdata,  // cmd[1:0], address[33:2]
  // result stream
  output logic                                   m_tvalid,
  input  wire logic                              m_tready,
  // granted[0], assigned_address[32:1], router_address[64:33], prefix_length[69:65]
  output logic [apba_pkg::OUT_BITS-1:0]          m_tdata
);
  import apba_pkg::*;

  localparam int BW = $clog2(WORD_BITS);
  localparam int AW = (POOL_WORDS > 1) ? $clog2(POOL_WORDS) : 1;
  localparam int CW = $clog2(POOL_WORDS + 1);

  // Configuration registers.
  logic [ADDR_W-1:0]   pool_base;
  logic [PREFIX_W-1:0] prefix_len;

  // Sequencer state.
  state_t state, state_next;
  cmd_t   op, op_next;
  logic [AW-1:0] idx, idx_next;
  logic second, second_next;
  logic [AW-1:0] scan_word, scan_word_next;
  logic [CW-1:0] words_in_use, words_in_use_next;
  logic [ADDR_W-1:0] start_addr, start_addr_next;
  logic [PREFIX_W-1:0] start_prefix, start_prefix_next;
  logic mark_free, mark_free_next;
  logic partial, partial_next;
  logic [BW-1:0] rem_last, rem_last_next;
  logic res_granted, res_granted_next;
  logic [ADDR_W-1:0] res_addr, res_addr_next;

  // Bitmap memory: bit set means the address is free.
  logic [WORD_BITS-1:0] free_map [POOL_WORDS];
  logic [WORD_BITS-1:0] rdata;
  logic [WORD_BITS-1:0] wdata;
  logic we;

  // Command word fields.
  cmd_t s_cmd;
  logic [ADDR_W-1:0] s_address;
  assign s_cmd     = cmd_t'(s_tdata[CMD_W-1:0]);
  assign s_address = s_tdata[CMD_W+ADDR_W-1:CMD_W];

  // Divider and bit finder.
  logic div_start, div_done;
  logic [ADDR_W-1:0] div_dividend, div_quo;
  logic [BW-1:0] div_rem;
  logic ffs_found;
  logic [BW-1:0] ffs_index;
  logic [WORD_BITS-1:0] ffs_cleared;

  apba_div #(.DIVISOR(WORD_BITS)) u_div (
    .clk       (clk),
    .rst       (rst),
    .start     (div_start),
    .dividend  (div_dividend),
    .done      (div_done),
    .quotient  (div_quo),
    .remainder (div_rem)
  );

  apba_ffs #(.WORD_BITS(WORD_BITS)) u_ffs (
    .word    (rdata),
    .found   (ffs_found),
    .index   (ffs_index),
    .cleared (ffs_cleared)
  );

  // Subnet geometry from the configured prefix.
  logic [ADDR_W-1:0] netmask;
  logic [ADDR_W-1:0] offset;
  logic prefix_ok;
  assign netmask   = {ADDR_W{1'b1}} << (6'd32 - {1'b0, prefix_len});
  assign prefix_ok = (prefix_len != '0) && (prefix_len <= MAX_PREFIX);
  assign offset    = s_address - start_addr;

  // Init word: all ones, last word trimmed below broadcast, network and router used.
  logic [WORD_BITS-1:0] fill_word;
  logic [WORD_BITS-1:0] last_mask;
  logic fill_last;
  assign fill_last = (32'(idx) + 32'd1) == 32'(words_in_use);
  assign last_mask = {WORD_BITS{1'b1}} >> (BW'(WORD_BITS - 1) - rem_last);

  always_comb begin
    fill_word = {WORD_BITS{1'b1}};
    if (partial && fill_last) begin
      fill_word = fill_word & last_mask;
    end
    if (idx == '0) begin
      fill_word = fill_word & {{(WORD_BITS-2){1'b1}}, 2'b00};
    end
  end

  logic [WORD_BITS-1:0] bit_mask;
  assign bit_mask = WORD_BITS'(1) << rem_last;

  logic out_free;
  assign out_free = !m_tvalid || m_tready;
  assign s_tready = (state == ST_IDLE);

  // Result word: hold all fields at zero unless the allocate succeeded.
  logic [OUT_BITS-1:0] res_word;
  always_comb begin
    res_word = '0;
    if (res_granted) begin
      res_word[0]                            = 1'b1;
      res_word[ADDR_W:1]                     = res_addr;
      res_word[2*ADDR_W:ADDR_W+1]            = start_addr + 32'd1;
      res_word[2*ADDR_W+PREFIX_W:2*ADDR_W+1] = start_prefix;
    end
  end

  always_comb begin
    state_next        = state;
    op_next           = op;
    idx_next          = idx;
    second_next       = second;
    scan_word_next    = scan_word;
    words_in_use_next = words_in_use;
    start_addr_next   = start_addr;
    start_prefix_next = start_prefix;
    mark_free_next    = mark_free;
    partial_next      = partial;
    rem_last_next     = rem_last;
    res_granted_next  = res_granted;
    res_addr_next     = res_addr;
    we                = 1'b0;
    wdata             = fill_word;
    div_start         = 1'b0;
    div_dividend      = offset;

    case (state)
      ST_IDLE: begin
        if (s_tvalid) begin
          op_next          = s_cmd;
          res_granted_next = 1'b0;
          case (s_cmd)
            CMD_ALLOC: begin
              state_next = ST_SCAN_GO;
            end
            CMD_RELEASE, CMD_RESERVE: begin
              mark_free_next = (s_cmd == CMD_RELEASE);
              // Offset zero is the network address: drop it.
              if (offset == '0) begin
                state_next = ST_DONE;
              end else begin
                div_start  = 1'b1;
                state_next = ST_DIV;
              end
            end
            CMD_INIT: begin
              if (prefix_ok) begin
                start_addr_next   = pool_base & netmask;
                start_prefix_next = prefix_len;
                div_dividend      = ~netmask - 32'd1;
                div_start         = 1'b1;
                state_next        = ST_DIV;
              end else begin
                // Bad prefix: empty pool.
                start_addr_next   = '0;
                start_prefix_next = '0;
                words_in_use_next = '0;
                scan_word_next    = '0;
                state_next        = ST_DONE;
              end
            end
            default: begin
              state_next = ST_DONE;
            end
          endcase
        end
      end

      ST_DIV: begin
        if (div_done) begin
          rem_last_next = div_rem;
          if (op == CMD_INIT) begin
            // Quotient is the last word index of the pool.
            if (div_quo >= 32'(POOL_WORDS)) begin
              words_in_use_next = CW'(POOL_WORDS);
              partial_next      = 1'b0;
            end else begin
              words_in_use_next = CW'(div_quo + 32'd1);
              partial_next      = 1'b1;
            end
            idx_next       = '0;
            scan_word_next = '0;
            state_next     = ST_FILL;
          end else if (div_quo >= 32'(words_in_use)) begin
            state_next = ST_DONE;
          end else begin
            idx_next   = div_quo[AW-1:0];
            state_next = ST_MARK_RD;
          end
        end
      end

      ST_FILL: begin
        we    = 1'b1;
        wdata = fill_word;
        if (fill_last) begin
          state_next = ST_DONE;
        end else begin
          idx_next = idx + AW'(1);
        end
      end

      ST_SCAN_GO: begin
        // Start at the remembered word, or wrap to word 0 when it is stale.
        if (32'(scan_word) < 32'(words_in_use)) begin
          idx_next    = scan_word;
          second_next = 1'b0;
          state_next  = ST_SCAN;
        end else if (scan_word != '0 && words_in_use != '0) begin
          idx_next    = '0;
          second_next = 1'b1;
          state_next  = ST_SCAN;
        end else begin
          scan_word_next = '0;
          state_next     = ST_DONE;
        end
      end

      ST_SCAN: begin
        if (ffs_found) begin
          we               = 1'b1;
          wdata            = ffs_cleared;
          scan_word_next   = idx;
          res_granted_next = 1'b1;
          res_addr_next    = start_addr + 32'(idx) * 32'(WORD_BITS) + 32'(ffs_index);
          state_next       = ST_DONE;
        end else if ((32'(idx) + 32'd1) < 32'(words_in_use)) begin
          idx_next = idx + AW'(1);
        end else if (!second && scan_word != '0) begin
          idx_next    = '0;
          second_next = 1'b1;
        end else begin
          scan_word_next = '0;
          state_next     = ST_DONE;
        end
      end

      ST_MARK_RD: begin
        state_next = ST_MARK_WR;
      end

      ST_MARK_WR: begin
        we         = 1'b1;
        wdata      = mark_free ? (rdata | bit_mask) : (rdata & ~bit_mask);
        state_next = ST_DONE;
      end

      ST_DONE: begin
        if (out_free) begin
          state_next = ST_IDLE;
        end
      end

      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

  // Read the word the sequencer visits next; write back at the current word.
  always_ff @(posedge clk) begin
    if (we) begin
      free_map[idx] <= wdata;
    end
    rdata <= free_map[idx_next];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      pool_base    <= '0;
      prefix_len   <= PREFIX_RESET;
      state        <= ST_IDLE;
      scan_word    <= '0;
      words_in_use <= '0;
      start_addr   <= '0;
      start_prefix <= '0;
      m_tvalid     <= 1'b0;
    end else begin
      if (cfg_we) begin
        case (cfg_index)
          REG_POOL_BASE:  pool_base  <= cfg_data;
          REG_PREFIX_LEN: prefix_len <= cfg_data[PREFIX_W-1:0];
          default: ;
        endcase
      end
      state        <= state_next;
      scan_word    <= scan_word_next;
      words_in_use <= words_in_use_next;
      start_addr   <= start_addr_next;
      start_prefix <= start_prefix_next;
      if (state == ST_DONE && out_free) begin
        m_tvalid <= 1'b1;
      end else if (m_tready) begin
        m_tvalid <= 1'b0;
      end
    end
  end

  // Working registers and the output word need no reset.
  always_ff @(posedge clk) begin
    op          <= op_next;
    idx         <= idx_next;
    second      <= second_next;
    mark_free   <= mark_free_next;
    partial     <= partial_next;
    rem_last    <= rem_last_next;
    res_granted <= res_granted_next;
    res_addr    <= res_addr_next;
    if (state == ST_DONE && out_free) begin
      m_tdata <= res_word;
    end
  end

endmodule
`default_nettype wire

FILE: tb/tb_top.sv
// Self-checking bench for the address pool allocator: streamed commands checked against a bitmap model.
module tb_top;
  timeunit 1ns;
  timeprecision 1ps;

  import apba_pkg::*;

  localparam int MAP_WORDS    = 64;
  localparam int MAP_BITS     = 64;
  localparam int CYCLE_LIMIT  = 1_000_000;
  localparam int DRAIN_CYCLES = 200;
  localparam int HOLD_CYCLES  = 400;
  localparam int RANDOM_ITEMS = 1200;
  localparam int REACH_CAP    = MAP_WORDS * MAP_BITS + 100;
  // Network and router offsets never start out free.
  localparam logic [MAP_BITS-1:0] RESERVED_LOW = 64'd3;

  typedef struct {
    cmd_t              op;
    logic [ADDR_W-1:0] addr;
  } pool_cmd_t;

  typedef struct packed {
    logic                granted;
    logic [ADDR_W-1:0]   assigned;
    logic [ADDR_W-1:0]   router;
    logic [PREFIX_W-1:0] prefix;
  } lease_t;

  // DUT connections; every input starts at a known value.
  logic                clk       = 1'b0;
  logic                rst       = 1'b1;
  logic                cfg_we    = 1'b0;
  logic                cfg_index = 1'b0;
  logic [ADDR_W-1:0]   cfg_data  = '0;
  logic                s_tvalid  = 1'b0;
  logic                s_tready;
  logic [IN_BITS-1:0]  s_tdata   = '0;   // cmd[1:0], address[33:2]
  logic                m_tvalid;
  logic                m_tready  = 1'b0;
  // granted[0], assigned_address[32:1], router_address[64:33], prefix_length[69:65]
  logic [OUT_BITS-1:0] m_tdata;

  address_pool_bitmap_allocator u_top (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .s_tvalid  (s_tvalid),
    .s_tready  (s_tready),
    .s_tdata   (s_tdata),
    .m_tvalid  (m_tvalid),
    .m_tready  (m_tready),
    .m_tdata   (m_tdata)
  );

  always #10 clk = ~clk;

  // Bench bookkeeping.
  pool_cmd_t   cmd_q[$];     // commands waiting for the driver
  lease_t      lease_q[$];   // predicted replies, oldest first
  int unsigned mismatches  = 0;
  int unsigned cycle_count = 0;
  int unsigned send_gap    = 0;
  int unsigned stall_left  = 0;
  int unsigned hold_left   = 0;
  bit          word_taken  = 1'b0;
  bit          hold_request = 1'b0;
  bit          calm        = 1'b0;   // no idling on either side while set

  // Pool model: configuration copy plus bitmap state (bit set = free address).
  logic [ADDR_W-1:0]   base_reg;
  logic [PREFIX_W-1:0] prefix_reg;
  logic [MAP_BITS-1:0] free_words [MAP_WORDS];
  int unsigned         scan_from_word;
  int unsigned         live_words;
  logic [ADDR_W-1:0]   net_start;
  logic [PREFIX_W-1:0] net_prefix;

  function automatic logic [MAP_BITS-1:0] ones_below(int unsigned n);
    if (n == 0) return '0;
    return {MAP_BITS{1'b1}} >> (MAP_BITS - n);
  endfunction

  // Rebuild the map from the configured base and prefix.
  function automatic void rebuild_pool();
    logic [ADDR_W-1:0] netmask;
    logic [ADDR_W-1:0] span;
    int unsigned       need;
    for (int w = 0; w < MAP_WORDS; w++) free_words[w] = '0;
    scan_from_word = 0;
    live_words     = 0;
    net_start      = '0;
    net_prefix     = '0;
    // A prefix of zero or past the maximum leaves the pool empty.
    if (prefix_reg == 0 || prefix_reg > MAX_PREFIX) return;
    netmask    = 32'hFFFF_FFFF << (32 - prefix_reg);
    net_start  = base_reg & netmask;
    net_prefix = prefix_reg;
    span       = ~netmask;   // broadcast offset
    need       = (span - 1) / MAP_BITS + 1;
    if (need > MAP_WORDS) begin
      // Pool larger than the map: truncate, broadcast lies outside.
      live_words = MAP_WORDS;
      for (int w = 0; w < MAP_WORDS; w++) free_words[w] = '1;
    end else begin
      live_words = need;
      for (int w = 0; w < need; w++) free_words[w] = '1;
      free_words[need-1] &= ones_below((span - 1) % MAP_BITS + 1);
    end
    free_words[0] &= ~RESERVED_LOW;
  endfunction

  // Lowest free bit from word 'first' up to the last live word.
  function automatic bit find_free(int unsigned first, output int unsigned wi,
                                   output int unsigned bi);
    wi = 0;
    bi = 0;
    for (int unsigned i = first; i < live_words && i < MAP_WORDS; i++)
      for (int k = 0; k < MAP_BITS; k++)
        if (free_words[i][k]) begin
          wi = i;
          bi = k;
          return 1'b1;
        end
    return 1'b0;
  endfunction

  // Apply one command to the model and return the reply it produces.
  function automatic lease_t predict_lease(pool_cmd_t c);
    lease_t            r;
    int unsigned       wi, bi;
    logic [ADDR_W-1:0] off;
    bit                hit;
    r = '0;
    case (c.op)
      CMD_ALLOC: begin
        // Next fit from the remembered word, then one wrap to word 0.
        hit = find_free(scan_from_word, wi, bi);
        if (!hit && scan_from_word != 0) begin
          scan_from_word = 0;
          hit = find_free(0, wi, bi);
        end
        if (!hit) begin
          scan_from_word = 0;
        end else begin
          free_words[wi][bi] = 1'b0;
          scan_from_word     = wi;
          r.granted  = 1'b1;
          r.assigned = net_start + wi * MAP_BITS + bi;
          r.router   = net_start + 1;
          r.prefix   = net_prefix;
        end
      end
      CMD_RELEASE, CMD_RESERVE: begin
        // Drop offset zero and anything past the last live word.
        off = c.addr - net_start;
        if (off != 0 && off / MAP_BITS < live_words)
          free_words[off / MAP_BITS][off % MAP_BITS] = (c.op == CMD_RELEASE);
      end
      default: rebuild_pool();
    endcase
    return r;
  endfunction

  // Mostly short gaps, now and then a long one.
  function automatic int unsigned pick_gap();
    int unsigned r;
    if (calm) return 0;
    r = $urandom_range(0, 99);
    if (r < 60) return 0;
    if (r < 92) return $urandom_range(1, 4);
    return $urandom_range(10, 40);
  endfunction

  function automatic logic [ADDR_W-1:0] pick_addr(logic [ADDR_W-1:0] first,
                                                  int unsigned reach);
    if ($urandom_range(0, 99) < 15) return $urandom();
    return first + $urandom_range(0, reach);
  endfunction

  task automatic check_field(string name, logic [ADDR_W-1:0] got, logic [ADDR_W-1:0] want);
    if (got !== want) begin
      mismatches++;
      if (mismatches <= 10)
        $display("%0t mismatch on %s: expected %h, got %h", $realtime, name, want, got);
    end
  endtask

  task automatic send(cmd_t op, logic [ADDR_W-1:0] a);
    cmd_q.push_back('{op, a});
  endtask

  // Write a register while the block is idle and mirror it in the model.
  task automatic write_reg(logic idx, logic [ADDR_W-1:0] value);
    @(negedge clk);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= value;
    @(negedge clk);
    cfg_we    <= 1'b0;
    if (idx == REG_POOL_BASE) base_reg = value;
    else prefix_reg = value[PREFIX_W-1:0];
  endtask

  // Hold until every queued word went in and every reply came back.
  task automatic wait_idle();
    do @(posedge clk);
    while (cmd_q.size() != 0 || s_tvalid || lease_q.size() != 0);
    repeat (4) @(negedge clk);
  endtask

  // Command driver: advance to the next word once the current one is taken.
  always @(negedge clk) begin
    pool_cmd_t c;
    if (rst) begin
      s_tvalid <= 1'b0;
    end else if (!s_tvalid || word_taken) begin
      word_taken = 1'b0;
      if (send_gap > 0) begin
        send_gap--;
        s_tvalid <= 1'b0;
      end else if (cmd_q.size() != 0) begin
        c = cmd_q.pop_front();
        s_tdata  <= IN_BITS'({c.addr, c.op});
        s_tvalid <= 1'b1;
        send_gap = pick_gap();
      end else begin
        s_tvalid <= 1'b0;
      end
    end
  end

  // Accepted command word: run the model and queue its reply.
  always @(posedge clk) begin
    pool_cmd_t c;
    if (!rst && s_tvalid && s_tready) begin
      c.op   = cmd_t'(s_tdata[CMD_W-1:0]);
      c.addr = s_tdata[CMD_W +: ADDR_W];
      lease_q.push_back(predict_lease(c));
      word_taken = 1'b1;
    end
  end

  // Reply receiver: random stalls, plus one long hold-off on request.
  always @(negedge clk) begin
    logic ready_next;
    ready_next = 1'b1;
    if (rst) begin
      ready_next = 1'b0;
    end else if (hold_request) begin
      hold_request = 1'b0;
      hold_left    = HOLD_CYCLES;
      ready_next   = 1'b0;
    end else if (hold_left > 0) begin
      hold_left--;
      ready_next = 1'b0;
    end else if (stall_left > 0) begin
      stall_left--;
      ready_next = 1'b0;
    end else if (!calm && $urandom_range(0, 99) < 20) begin
      stall_left = pick_gap();
      ready_next = (stall_left == 0);
    end
    m_tready <= ready_next;
  end

  // Reply monitor: compare each accepted word with the oldest prediction.
  always @(posedge clk) begin
    lease_t want;
    if (!rst && m_tvalid && m_tready) begin
      if (lease_q.size() == 0) begin
        mismatches++;
        if (mismatches <= 10)
          $display("%0t reply word with nothing outstanding: %h", $realtime, m_tdata);
      end else begin
        want = lease_q.pop_front();
        check_field("granted", ADDR_W'(m_tdata[0]), ADDR_W'(want.granted));
        check_field("assigned_address", m_tdata[32:1], want.assigned);
        check_field("router_address", m_tdata[64:33], want.router);
        check_field("prefix_length", ADDR_W'(m_tdata[69:65]), ADDR_W'(want.prefix));
      end
    end
  end

  // Watchdog.
  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("tb: failure");
      $finish;
    end
  end

  initial begin
    logic [ADDR_W-1:0]   base;
    logic [ADDR_W-1:0]   mask;
    logic [ADDR_W-1:0]   first;
    logic [PREFIX_W-1:0] pfx;
    logic [ADDR_W-1:0]   s;
    int unsigned         reach, n, r, sent_random, phase;
    cmd_t                op;

    // Model state after reset: registers at their reset values, pool empty.
    base_reg   = '0;
    prefix_reg = PREFIX_RESET;
    for (int w = 0; w < MAP_WORDS; w++) free_words[w] = '0;
    scan_from_word = 0;
    live_words     = 0;
    net_start      = '0;
    net_prefix     = '0;
    sent_random = 0;
    phase       = 0;

    repeat (7) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // Before any init the map is empty: allocate fails, marks are dropped.
    send(CMD_ALLOC, 32'h0);
    send(CMD_RELEASE, 32'h0000_0001);
    send(CMD_RESERVE, 32'hFFFF_FFFF);
    wait_idle();

    // Smallest pool: a /30 leaves only offset 2 free; base gets masked.
    write_reg(REG_POOL_BASE, 32'hC0A8_0137);
    write_reg(REG_PREFIX_LEN, 32'd30);
    s = 32'hC0A8_0134;
    send(CMD_INIT, 32'h0);
    send(CMD_ALLOC, 32'h0);
    send(CMD_ALLOC, 32'h0);                 // exhausted
    send(CMD_RELEASE, s + 3);               // broadcast can be freed
    send(CMD_ALLOC, s + 3);
    send(CMD_RELEASE, s);                   // offset zero is dropped
    send(CMD_RESERVE, s + MAP_BITS);        // beyond the last word
    send(CMD_RELEASE, s + 2);
    send(CMD_RESERVE, s + 2);
    send(CMD_ALLOC, 32'h0);                 // fails, scan word back to 0
    send(CMD_RELEASE, s + 1);               // router slot freed by hand
    send(CMD_ALLOC, 32'h0);
    wait_idle();

    // Bad prefixes give an empty pool.
    write_reg(REG_PREFIX_LEN, 32'd0);
    send(CMD_INIT, 32'h0);
    send(CMD_ALLOC, 32'h0);
    wait_idle();
    write_reg(REG_PREFIX_LEN, 32'd31);
    send(CMD_INIT, 32'h0);
    send(CMD_ALLOC, 32'h0);
    wait_idle();

    // Huge pool truncated to the map; top bit of the last word stays free.
    write_reg(REG_POOL_BASE, 32'hFFFF_FFFF);
    write_reg(REG_PREFIX_LEN, 32'd1);
    send(CMD_INIT, 32'h0);
    send(CMD_ALLOC, 32'h0);
    send(CMD_RELEASE, 32'h8000_0000 + MAP_WORDS * MAP_BITS - 1);
    send(CMD_RESERVE, 32'h8000_0000 + MAP_WORDS * MAP_BITS);
    wait_idle();

    // Largest pool that fills the map exactly; broadcast sits in the last bit.
    write_reg(REG_POOL_BASE, 32'h0);
    write_reg(REG_PREFIX_LEN, 32'd20);
    send(CMD_INIT, 32'h0);
    send(CMD_RELEASE, 32'd4095);
    send(CMD_ALLOC, 32'h0);
    wait_idle();

    // Random phases: new subnet, init, then a burst of commands near the pool.
    while (sent_random < RANDOM_ITEMS) begin
      phase++;
      r = $urandom_range(0, 99);
      if (r < 10) base = '0;
      else if (r < 20) base = '1;
      else base = $urandom();
      r = $urandom_range(0, 99);
      if (r < 65) pfx = PREFIX_W'($urandom_range(25, 30));
      else if (r < 85) pfx = PREFIX_W'($urandom_range(20, 24));
      else pfx = PREFIX_W'($urandom_range(0, 31));
      write_reg(REG_POOL_BASE, base);
      write_reg(REG_PREFIX_LEN, ADDR_W'(pfx));

      // Keep the random addresses clustered around the live pool.
      if (pfx == 0 || pfx > MAX_PREFIX) begin
        first = base;
        reach = REACH_CAP;
      end else begin
        mask  = 32'hFFFF_FFFF << (32 - pfx);
        first = base & mask;
        reach = (~mask + 2 > REACH_CAP) ? REACH_CAP : ~mask + 2;
      end

      calm = ($urandom_range(0, 3) == 0);
      // One phase stalls the reply side hard while commands keep coming.
      if (phase == 3) begin
        calm = 1'b0;
        hold_request = 1'b1;
      end

      send(CMD_INIT, $urandom());
      n = $urandom_range(60, 140);
      repeat (n) begin
        r = $urandom_range(0, 99);
        if (r < 48) op = CMD_ALLOC;
        else if (r < 72) op = CMD_RELEASE;
        else if (r < 94) op = CMD_RESERVE;
        else op = CMD_INIT;
        send(op, pick_addr(first, reach));
      end
      sent_random += n + 1;
      wait_idle();
    end

    calm = 1'b0;
    wait_idle();
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (mismatches == 0)
      $display("tb: success");
    else
      $display("tb: failure");
    $finish;
  end

endmodule

FILE: filelist.f
sv/apba_pkg.sv
sv/apba_div.sv
sv/apba_ffs.sv
sv/address_pool_bitmap_allocator.sv
tb/tb_top.sv
